/* rtl/core/bsmd_pkg.sv */
// Package: shared types and constants for the studentized maximum deviation block.
package bsmd_pkg;

   typedef struct packed {
      logic [1:0]         mode;
      logic [6:0]         time_index;
      logic [5:0]         unit_index;
      logic signed [31:0] sample_value;
      logic signed [31:0] centre_value;
      logic signed [31:0] weight;
      logic               last_weight;
   } req_type;

   typedef struct packed {
      logic [31:0] max_deviation;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_CENTRE = 2'd1;
   localparam logic [1:0] MODE_WEIGHT = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
   localparam logic [1:0] STATUS_SUM      = 2'd2;

   localparam logic [1:0] CSR_TIME_POINTS   = 2'd0;
   localparam logic [1:0] CSR_UNIT_COUNT    = 2'd1;
   localparam logic [1:0] CSR_RIDGE         = 2'd2;
   localparam logic [1:0] CSR_SUM_TOLERANCE = 2'd3;

   localparam int TOT_W  = 40;
   localparam int MEAN_W = 34;
   localparam int AD_W   = 34;
   localparam int VAR_W  = 108;
   localparam int DIV_NW = 108;
   localparam int DIV_DW = 39;
   localparam int SQ_IW  = 78;
   localparam int SQ_RW  = 39;
   localparam int SQ_MW  = 41;
   localparam int BEST_W = 50;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_JUDGE,
      ST_MEAN,
      ST_ROUND,
      ST_VAR,
      ST_VSTART,
      ST_DIVV,
      ST_QSTART,
      ST_SQRT,
      ST_ZSTART,
      ST_DIVZ,
      ST_NEXT,
      ST_OUT
   } state_type;

endpackage

/* rtl/core/bsmd_div.sv */
// Restoring divider, one quotient bit per cycle.
module bsmd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bsmd_pkg::DIV_NW-1:0]   dividend,
   input  logic [bsmd_pkg::DIV_DW-1:0]   divisor,
   output logic                          done,
   output logic [bsmd_pkg::DIV_NW-1:0]   quotient
);
   import bsmd_pkg::*;

   localparam int CW = $clog2(DIV_NW);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DIV_DW-1:0] rem_ff;
   logic [DIV_DW-1:0] dsr_ff;
   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW:0]   rem_sh;
   logic              fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_NW-1]};
      fits   = rem_sh >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(DIV_NW - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CW'(DIV_NW - 1)) begin
               busy_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? DIV_DW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DIV_DW-1:0];
         quo_ff <= {quo_ff[DIV_NW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/bsmd_sqrt.sv */
// Integer square root, one result bit per cycle.
module bsmd_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bsmd_pkg::SQ_IW-1:0]   radicand,
   output logic                         done,
   output logic [bsmd_pkg::SQ_RW-1:0]   root
);
   import bsmd_pkg::*;

   localparam int CW = $clog2(SQ_RW);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [SQ_IW-1:0] opnd_ff;
   logic [SQ_MW-1:0] rem_ff;
   logic [SQ_RW-1:0] root_ff;
   logic [SQ_MW+1:0] rem_sh;
   logic [SQ_MW+1:0] trial;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff, opnd_ff[SQ_IW-1:SQ_IW-2]};
      trial  = (SQ_MW+2)'({root_ff, 2'b01});
      fits   = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(SQ_RW - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CW'(SQ_RW - 1)) begin
               busy_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         opnd_ff <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         opnd_ff <= {opnd_ff[SQ_IW-3:0], 2'b00};
         rem_ff  <= fits ? SQ_MW'(rem_sh - trial) : SQ_MW'(rem_sh);
         root_ff <= {root_ff[SQ_RW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/core/bootstrap_studentized_max_deviation.sv */
// Top level: weighted bootstrap studentized maximum deviation over stored curves.
// Load items (sample, centre, weight) are accepted only while idle and give no result.
// A weight item with the last flag starts a pass: a row check of the weights, then per
// time point a weighted-mean stream, a variance stream, a variance divide, a square root
// and a deviation divide on the shared serial divider and root unit; input stalls.
// Synchronous active-high reset clears control, presets config; stores are not cleared.
module bootstrap_studentized_max_deviation #(
   parameter int MAX_TIME  = 128,
   parameter int MAX_UNITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsmd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);
   import bsmd_pkg::*;

   localparam int TW = $clog2(MAX_TIME);
   localparam int UW = $clog2(MAX_UNITS);
   localparam int AW = $clog2(MAX_TIME * MAX_UNITS);

   logic [31:0] sample_mem [MAX_TIME * MAX_UNITS];
   logic [31:0] centre_mem [MAX_TIME];
   logic [31:0] weight_mem [MAX_UNITS];

   logic [7:0]  tp_ff;
   logic [6:0]  uc_ff;
   logic [30:0] ridge_ff;
   logic [9:0]  tol_ff;

   state_type state_ff, state_in;

   logic              acc_req;
   logic              ti_ok, ui_ok;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       sample_rd_ff, weight_rd_ff, centre_rd_ff;

   logic [TW-1:0]     t_ff, t_last;
   logic [AW-1:0]     row_base_ff;
   logic [UW-1:0]     j_ff, u_last;
   logic              issue_ff;
   logic [3:0]        vld_ff;
   logic              sdone;
   logic              launch;
   logic [DIV_DW-1:0] udiv;
   logic [30:0]       floor_se;

   logic [TOT_W-1:0]  tot_ff;
   logic              neg_ff;
   logic [TOT_W-1:0]  dev;
   logic [TOT_W-1:0]  dev_abs;
   logic              row_bad;
   logic [1:0]        status_ff;

   logic signed [63:0] prod_ff, acc_ff, rnd;
   logic [MEAN_W-1:0]  mean_ff;
   logic [34:0]        d;
   logic [33:0]        a_ff;
   logic [31:0]        w1_ff, w2_ff;
   logic [67:0]        sq_ff;
   logic [65:0]        plo_ff, phi_ff;
   logic [VAR_W-1:0]   var_ff;
   logic [SQ_IW-1:0]   vq_ff;
   logic [DIV_DW-1:0]  se_ff;
   logic [34:0]        cd;
   logic [AD_W-1:0]    ad;
   logic [BEST_W-1:0]  best_ff;

   logic              div_start, sqrt_start, div_done, sqrt_done;
   logic [DIV_NW-1:0] div_nd, div_q;
   logic [DIV_DW-1:0] div_ds;
   logic [SQ_RW-1:0]  sq_root;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign acc_req   = req_valid && !req_stall;
   assign ti_ok     = int'(req_data.time_index) < MAX_TIME;
   assign ui_ok     = int'(req_data.unit_index) < MAX_UNITS;
   assign wr_addr   = AW'(int'(req_data.time_index) * MAX_UNITS + int'(req_data.unit_index));
   assign rd_addr   = row_base_ff + AW'(j_ff);

   always_comb begin
      int tn, un;
      tn = int'(tp_ff);
      if (tn < 1) tn = 1;
      if (tn > MAX_TIME) tn = MAX_TIME;
      un = int'(uc_ff);
      if (un < 2) un = 2;
      if (un > MAX_UNITS) un = MAX_UNITS;
      t_last   = TW'(tn - 1);
      u_last   = UW'(un - 1);
      udiv     = DIV_DW'(un - 1);
      floor_se = (ridge_ff == 31'd0) ? 31'd1 : ridge_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff    <= 8'd128;
         uc_ff    <= 7'd64;
         ridge_ff <= 31'd1;
         tol_ff   <= 10'd11;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_POINTS:   tp_ff    <= csr_wdata[7:0];
            CSR_UNIT_COUNT:    uc_ff    <= csr_wdata[6:0];
            CSR_RIDGE:         ridge_ff <= csr_wdata;
            CSR_SUM_TOLERANCE: tol_ff   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (acc_req && req_data.mode == MODE_SAMPLE && ti_ok && ui_ok) begin
         sample_mem[wr_addr] <= req_data.sample_value;
      end
      sample_rd_ff <= sample_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (acc_req && req_data.mode == MODE_CENTRE && ti_ok) begin
         centre_mem[TW'(req_data.time_index)] <= req_data.centre_value;
      end
      centre_rd_ff <= centre_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_req && req_data.mode == MODE_WEIGHT && ui_ok) begin
         weight_mem[UW'(req_data.unit_index)] <= req_data.weight;
      end
      weight_rd_ff <= weight_mem[j_ff];
   end

   assign sdone = !issue_ff && (vld_ff == 4'd0);

   always_comb begin
      dev     = tot_ff - TOT_W'(64'd1 << 30);
      dev_abs = dev[TOT_W-1] ? TOT_W'(-dev) : dev;
      row_bad = neg_ff || (dev_abs > TOT_W'(tol_ff));
      rnd     = acc_ff + 64'sd536870912;
      d       = {{3{sample_rd_ff[31]}}, sample_rd_ff} - {mean_ff[MEAN_W-1], mean_ff};
      cd      = {mean_ff[MEAN_W-1], mean_ff} - {{3{centre_rd_ff[31]}}, centre_rd_ff};
      ad      = cd[34] ? AD_W'(-cd) : cd[AD_W-1:0];
      rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      launch     = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      div_nd     = var_ff;
      div_ds     = udiv;
      case (state_ff)
         ST_IDLE: begin
            if (acc_req && req_data.mode == MODE_WEIGHT && req_data.last_weight) begin
               launch   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sdone) state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            if (row_bad) begin
               state_in = ST_OUT;
            end else begin
               launch   = 1'b1;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (sdone) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            launch   = 1'b1;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            if (sdone) state_in = ST_VSTART;
         end
         ST_VSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIVV;
         end
         ST_DIVV: begin
            if (div_done) state_in = ST_QSTART;
         end
         ST_QSTART: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) state_in = ST_ZSTART;
         end
         ST_ZSTART: begin
            div_start = 1'b1;
            div_nd    = DIV_NW'({ad, 16'h0000});
            div_ds    = se_ff;
            state_in  = ST_DIVZ;
         end
         ST_DIVZ: begin
            if (div_done) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (t_ff == t_last) begin
               state_in = ST_OUT;
            end else begin
               launch   = 1'b1;
               state_in = ST_MEAN;
            end
         end
         ST_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         vld_ff   <= '0;
         j_ff     <= '0;
         tot_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         vld_ff <= {vld_ff[2:0], issue_ff};
         if (launch) begin
            issue_ff <= 1'b1;
            j_ff     <= '0;
         end else if (issue_ff) begin
            if (j_ff == u_last) begin
               issue_ff <= 1'b0;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         if (state_ff == ST_IDLE && launch) begin
            tot_ff <= '0;
            neg_ff <= 1'b0;
         end else if (state_ff == ST_CHECK && vld_ff[0]) begin
            tot_ff <= tot_ff + {{(TOT_W-32){weight_rd_ff[31]}}, weight_rd_ff};
            neg_ff <= neg_ff | weight_rd_ff[31];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_JUDGE: begin
            best_ff     <= '0;
            t_ff        <= '0;
            row_base_ff <= '0;
            acc_ff      <= '0;
            status_ff   <= neg_ff ? STATUS_NEGATIVE : (row_bad ? STATUS_SUM : STATUS_OK);
         end
         ST_MEAN: begin
            if (vld_ff[0]) prod_ff <= $signed(weight_rd_ff) * $signed(sample_rd_ff);
            if (vld_ff[1]) acc_ff <= acc_ff + prod_ff;
         end
         ST_ROUND: begin
            mean_ff <= rnd[63:30];
            var_ff  <= '0;
         end
         ST_VAR: begin
            if (vld_ff[0]) begin
               a_ff  <= d[34] ? 34'(-d) : d[33:0];
               w1_ff <= weight_rd_ff;
            end
            if (vld_ff[1]) begin
               sq_ff <= a_ff * a_ff;
               w2_ff <= w1_ff;
            end
            if (vld_ff[2]) begin
               plo_ff <= sq_ff[33:0] * w2_ff;
               phi_ff <= sq_ff[67:34] * w2_ff;
            end
            if (vld_ff[3]) begin
               var_ff <= var_ff + VAR_W'(plo_ff) + (VAR_W'(phi_ff) << 34);
            end
         end
         ST_DIVV: begin
            if (div_done) vq_ff <= div_q[DIV_NW-1:30];
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               se_ff <= (sq_root < DIV_DW'(floor_se)) ? DIV_DW'(floor_se) : sq_root;
            end
         end
         ST_DIVZ: begin
            if (div_done && div_q[BEST_W-1:0] > best_ff) best_ff <= div_q[BEST_W-1:0];
         end
         ST_NEXT: begin
            if (t_ff != t_last) begin
               t_ff        <= t_ff + 1'b1;
               row_base_ff <= row_base_ff + AW'(MAX_UNITS);
               acc_ff      <= '0;
            end
         end
         default: ;
      endcase
   end

   bsmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_nd),
      .divisor  (div_ds),
      .done     (div_done),
      .quotient (div_q)
   );

   bsmd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (vq_ff),
      .done     (sqrt_done),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.max_deviation <= (|best_ff[BEST_W-1:32]) ? 32'hFFFF_FFFF : best_ff[31:0];
         rsp_data_ff.status        <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/bsmd_checker.sv */
// Port checker for the studentized maximum deviation block, with its bind.
module bsmd_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bsmd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bsmd_pkg::rsp_type rsp_data
);
   import bsmd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_NEGATIVE ||
                     rsp_data.status == STATUS_SUM))
      else $error("bad status code");

   a_bad_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.max_deviation == 32'd0)
      else $error("rejected row with nonzero deviation");

   a_pass_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_WEIGHT && req_data.last_weight
      |=> req_stall)
      else $error("input not stalled during pass");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bootstrap_studentized_max_deviation bsmd_props u_bsmd_props (.*);
